// ----- hw/rtl/tlds_pkg.sv -----
// ----------------------------------------------------------------------------
// tlds_pkg
// Shared types, constants and tables of the text line decrypt and strip core.
// ----------------------------------------------------------------------------
package tlds_pkg;

    localparam int CHAR_W       = 16;
    localparam int MODE_W       = 2;
    localparam int KEY_W        = 4;
    localparam int MARKER_LEN   = 9;
    localparam int HELD_W       = $clog2(MARKER_LEN);
    localparam int QUEUE_DEPTH  = 4;

    // crypt status codes
    localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DETECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CRYPT  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL   = 16'd0;
    localparam logic [CHAR_W-1:0] CH_LF    = 16'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 16'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'd32;
    localparam logic [CHAR_W-1:0] CH_HASH  = 16'd35;
    localparam logic [CHAR_W:0]   WRAP_LOW = 17'd33;
    localparam logic [CHAR_W:0]   WRAP_ADD = 17'd95;

    typedef enum logic [0:0] {
        OP_CHAR = 1'b0,   // held marker chars (if any), then the item's char
        OP_MEND = 1'b1    // marker completed on the last char of a line
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic                crypt;
        logic [HELD_W-1:0]   held;
        logic [CHAR_W-1:0]   ch;
        logic                last;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    function automatic logic [5:0] key_offset(input logic [KEY_W-1:0] idx);
        logic [5:0] v;
        case (idx)
            4'd0:    v = 6'd31;
            4'd1:    v = 6'd7;
            4'd2:    v = 6'd9;
            4'd3:    v = 6'd1;
            4'd4:    v = 6'd11;
            4'd5:    v = 6'd2;
            4'd6:    v = 6'd5;
            4'd7:    v = 6'd5;
            4'd8:    v = 6'd3;
            4'd9:    v = 6'd17;
            4'd10:   v = 6'd40;
            4'd11:   v = 6'd12;
            4'd12:   v = 6'd35;
            4'd13:   v = 6'd22;
            4'd14:   v = 6'd27;
            default: v = 6'd2;
        endcase
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] marker_char(input logic [HELD_W-1:0] idx);
        logic [CHAR_W-1:0] v;
        case (idx)
            4'd0:    v = 16'h0072;  // r
            4'd1:    v = 16'h0065;  // e
            4'd2:    v = 16'h0064;  // d
            4'd3:    v = 16'h0073;  // s
            4'd4:    v = 16'h0068;  // h
            4'd5:    v = 16'h0069;  // i
            4'd6:    v = 16'h0072;  // r
            4'd7:    v = 16'h0074;  // t
            4'd8:    v = 16'h0032;  // 2
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/text_line_decrypt_and_strip_core.sv -----
// ----------------------------------------------------------------------------
// text_line_decrypt_and_strip_core
// Marker detection, per-character decryption and line cut of a text stream.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_in_char, i_line_last
//  result    out        o_valid / i_ready    o_out_char, o_char_valid, o_line_end
//  config    in         i_cfg_wr_en          i_cfg_wr_data (start_mode)
//
//  One character per cycle in steady state, unless the output stalls; an item
//  enters the command queue when accepted and is then loaded into the output
//  register. A marker mismatch releases up to nine results from one item, one
//  per cycle while the output is not stalled, stepped by the release counter
//  of the back part; the queue keeps taking items meanwhile until it fills.
//  Reset or a start_mode write sets mode, clears key index, line flags and queue.
// ----------------------------------------------------------------------------
module text_line_decrypt_and_strip_core
    import tlds_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [MODE_W-1:0]   i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CHAR_W-1:0]   i_in_char,
    input  logic                i_line_last,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHAR_W-1:0]   o_out_char,
    output logic                o_char_valid,
    output logic                o_line_end
);

    logic q_full, q_push, q_pop, q_valid;
    t_cmd push_cmd, head_cmd;

    tlds_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_char     (i_in_char),
        .i_line_last   (i_line_last),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    tlds_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (i_cfg_wr_en),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    tlds_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (i_cfg_wr_en),
        .i_q_valid    (q_valid),
        .i_cmd        (head_cmd),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_line_end   (o_line_end)
    );

endmodule

// ----- hw/rtl/tlds_front.sv -----
// ----------------------------------------------------------------------------
// tlds_front
// Accepts characters, tracks the marker match and issues commands.
// ----------------------------------------------------------------------------
module tlds_front
    import tlds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [MODE_W-1:0]   i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CHAR_W-1:0]   i_in_char,
    input  logic                i_line_last,
    input  logic                i_q_full,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic [MODE_W-1:0] r_status, n_status;
    logic [HELD_W-1:0] r_matched, n_matched;
    logic              accept;
    logic [HELD_W-1:0] m;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        n_status  = r_status;
        n_matched = r_matched;
        o_push    = 1'b0;
        m         = (r_matched >= HELD_W'(MARKER_LEN)) ? '0 : r_matched;
        o_cmd.op    = OP_CHAR;
        o_cmd.crypt = 1'b0;
        o_cmd.held  = '0;
        o_cmd.ch    = i_in_char;
        o_cmd.last  = i_line_last;
        if (accept) begin
            if (r_status == MODE_PLAIN) begin
                o_push = 1'b1;
            end else if (r_status != MODE_DETECT) begin
                o_push      = 1'b1;
                o_cmd.crypt = 1'b1;
            end else if (i_in_char == marker_char(m)) begin
                if (m == HELD_W'(MARKER_LEN - 1)) begin
                    n_status  = MODE_CRYPT;
                    n_matched = '0;
                    o_push    = i_line_last;
                    o_cmd.op  = OP_MEND;
                end else if (!i_line_last) begin
                    n_matched = m + 1'b1;
                end else begin
                    // line too short for the marker: release as plain text
                    n_status   = MODE_PLAIN;
                    n_matched  = '0;
                    o_push     = 1'b1;
                    o_cmd.held = m;
                end
            end else begin
                n_status   = MODE_PLAIN;
                n_matched  = '0;
                o_push     = 1'b1;
                o_cmd.held = m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= MODE_DETECT;
            r_matched <= '0;
        end else if (i_cfg_wr_en) begin
            r_status  <= i_cfg_wr_data;
            r_matched <= '0;
        end else begin
            r_status  <= n_status;
            r_matched <= n_matched;
        end
    end

endmodule

// ----- hw/rtl/tlds_queue.sv -----
// ----------------------------------------------------------------------------
// tlds_queue
// Small command FIFO between the front and the back part.
// ----------------------------------------------------------------------------
module tlds_queue
    import tlds_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_flush,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_cmd    o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/tlds_back.sv -----
// ----------------------------------------------------------------------------
// tlds_back
// Executes commands: releases held marker chars, decrypts and cuts lines.
// ----------------------------------------------------------------------------
module tlds_back
    import tlds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  logic                i_q_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHAR_W-1:0]   o_out_char,
    output logic                o_char_valid,
    output logic                o_line_end
);

    logic [KEY_W-1:0]  r_key, n_key;
    logic              r_cut, n_cut;
    logic              r_stopped, n_stopped;
    logic [HELD_W-1:0] r_idx;
    logic              r_o_valid;
    logic [CHAR_W-1:0] r_o_char, res_char;
    logic              r_o_char_valid, res_valid;
    logic              r_o_line_end, res_end;
    logic              step, at_item;
    logic [CHAR_W-1:0] d;
    logic [CHAR_W:0]   diff;

    assign step    = i_q_valid && (!r_o_valid || i_ready);
    assign at_item = (r_idx == i_cmd.held) || (i_cmd.op == OP_MEND);
    assign o_pop   = step && at_item;

    always_comb begin
        n_key     = r_key;
        n_cut     = r_cut;
        n_stopped = r_stopped;
        res_valid = 1'b0;
        res_end   = 1'b0;
        diff      = '0;
        d         = (r_idx == i_cmd.held) ? i_cmd.ch : marker_char(r_idx);
        if (i_cmd.op == OP_MEND) begin
            d       = '0;
            res_end = 1'b1;
        end else begin
            res_end = (r_idx == i_cmd.held) && i_cmd.last;
            if (!r_stopped) begin
                if (d == CH_NUL) begin
                    n_stopped = 1'b1;
                end else begin
                    if (i_cmd.crypt && (d > CH_SPACE)) begin
                        n_key = r_key + 1'b1;
                        diff  = {1'b0, d} - (CHAR_W + 1)'(key_offset(n_key));
                        // wrap back into the printable range
                        if (diff[CHAR_W] || (diff < WRAP_LOW)) begin
                            diff = diff + WRAP_ADD;
                        end
                        d = diff[CHAR_W-1:0];
                    end
                    if (!r_cut) begin
                        if (d inside {CH_HASH, CH_LF, CH_CR}) begin
                            n_cut = 1'b1;
                        end else begin
                            res_valid = 1'b1;
                        end
                    end
                end
            end
        end
        if (res_end) begin
            n_cut     = 1'b0;
            n_stopped = 1'b0;
        end
        res_char = res_valid ? d : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_key     <= '0;
            r_cut     <= 1'b0;
            r_stopped <= 1'b0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (step) begin
                r_key     <= n_key;
                r_cut     <= n_cut;
                r_stopped <= n_stopped;
                r_idx     <= at_item ? '0 : r_idx + 1'b1;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_o_char       <= res_char;
            r_o_char_valid <= res_valid;
            r_o_line_end   <= res_end;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_char   = r_o_char;
    assign o_char_valid = r_o_char_valid;
    assign o_line_end   = r_o_line_end;

endmodule
